[design/salc_pkg.sv]
// ============================================================================
// salc_pkg: shared constants and types for the LRU cache tag store
// Default geometry, fixed result field widths, and the status group passed
// from the way update logic to the top level.
// ============================================================================
package salc_pkg;

    // default geometry
    localparam int NUM_SETS_DEF   = 64;
    localparam int NUM_WAYS_DEF   = 8;
    localparam int LINE_BYTES_DEF = 64;
    localparam int ADDR_BITS_DEF  = 48;

    // fixed result field widths
    localparam int WAY_OUT_W = 3;
    localparam int SET_OUT_W = 6;
    localparam int TAG_OUT_W = 36;
    localparam int CNT_W     = 48;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // per-access lookup status
    typedef struct packed {
        logic hit;
        logic evicted;
    } salc_status_t;

endpackage

[design/set_assoc_lru_cache_tags.sv]
// ============================================================================
// set_assoc_lru_cache_tags: set-associative cache tag store, true LRU
// Looks up one byte address per cycle, fills or replaces on a miss, and
// keeps saturating hit and miss totals.
// ============================================================================
// Usage:
//   Command channel: pulse start with address; a beat is taken on every
//   clock edge with start high and busy low. busy never rises, so one
//   access can be issued every cycle.
//   Result channel: done is high for one cycle with hit, way_used,
//   set_index, evicted, evicted_tag, hit_total and miss_total. There is no
//   back pressure; the receiver must take the beat in that cycle.
//   Result path: set row read from the row memory, then compare/update
//   into the result registers. Throughput: one access per cycle, set by
//   the single row memory read port; a row written by the previous access
//   is forwarded when the next access hits the same set.
//   Reset: all lines invalid and both totals zero at once. The valid bits
//   live in the row memory; one written flag per set masks them until the
//   set's row is first written, so the memory needs no clearing pass.
//   hit_total and miss_total hold their last values between results.
// ============================================================================
module set_assoc_lru_cache_tags
    import salc_pkg::*;
#(
    parameter int NUM_SETS   = NUM_SETS_DEF,
    parameter int NUM_WAYS   = NUM_WAYS_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 busy,
    output logic                 done,
    output logic                 hit,
    output logic [WAY_OUT_W-1:0] way_used,
    output logic [SET_OUT_W-1:0] set_index,
    output logic                 evicted,
    output logic [TAG_OUT_W-1:0] evicted_tag,
    output logic [CNT_W-1:0]     hit_total,
    output logic [CNT_W-1:0]     miss_total
);

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int TAG_W  = ADDR_BITS - OFF_W - SET_W;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W  = WAY_W;
    localparam int ROW_W  = NUM_WAYS * (1 + TAG_W + AGE_W);

    logic accept;

    // stage 1: access whose set row is being read out
    logic             s1_valid_reg;
    logic [SET_W-1:0] s1_set_reg;
    logic [TAG_W-1:0] s1_tag_reg;

    // forward path for back-to-back accesses to the same set
    logic             byp_valid_reg;
    logic [SET_W-1:0] byp_set_reg;
    logic [ROW_W-1:0] byp_row_reg;

    // set row written since reset
    logic [NUM_SETS-1:0] row_init_reg;

    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_next;

    logic                 done_reg;
    logic                 hit_reg;
    logic [WAY_OUT_W-1:0] way_reg;
    logic [SET_OUT_W-1:0] set_reg;
    logic                 evicted_reg;
    logic [TAG_OUT_W-1:0] evtag_reg;

    logic [ROW_W-1:0]                  ram_rdata;
    logic [ROW_W-1:0]                  row_cur;
    logic [ROW_W-1:0]                  row_new;
    logic [NUM_WAYS-1:0]               valid_mem;
    logic [NUM_WAYS-1:0][TAG_W-1:0]    tag_row;
    logic [NUM_WAYS-1:0][AGE_W-1:0]    age_row;
    logic [NUM_WAYS-1:0][TAG_W-1:0]    tag_new;
    logic [NUM_WAYS-1:0][AGE_W-1:0]    age_new;
    logic [NUM_WAYS-1:0]               valid_row;
    logic [NUM_WAYS-1:0]               valid_new;
    salc_status_t                      status;
    logic [WAY_W-1:0]                  way;
    logic [TAG_W-1:0]                  old_tag;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    salc_row_ram #(
        .DEPTH  (NUM_SETS),
        .WIDTH  (ROW_W),
        .ADDR_W (SET_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_set_reg),
        .wdata (row_new),
        .re    (accept),
        .raddr (address[OFF_W +: SET_W]),
        .rdata (ram_rdata)
    );

    // the memory read at the accepting edge misses a write at that same edge
    assign row_cur = (byp_valid_reg && byp_set_reg == s1_set_reg) ? byp_row_reg : ram_rdata;
    assign {valid_mem, tag_row, age_row} = row_cur;
    assign row_new            = {valid_new, tag_new, age_new};
    // a set never written since reset has no valid way
    assign valid_row          = row_init_reg[s1_set_reg] ? valid_mem : '0;

    salc_way_update #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W)
    ) u_way_update (
        .valid_row (valid_row),
        .tag_row   (tag_row),
        .age_row   (age_row),
        .tag       (s1_tag_reg),
        .status    (status),
        .way       (way),
        .old_tag   (old_tag),
        .valid_new (valid_new),
        .tag_new   (tag_new),
        .age_new   (age_new)
    );

    // saturating totals
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (s1_valid_reg)
        begin
            if (status.hit)
            begin
                if (hit_cnt_reg != CNT_MAX)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            else if (miss_cnt_reg != CNT_MAX)
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            row_init_reg  <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            byp_valid_reg <= s1_valid_reg;
            done_reg      <= s1_valid_reg;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            if (s1_valid_reg)
            begin
                row_init_reg[s1_set_reg] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg <= address[OFF_W +: SET_W];
            s1_tag_reg <= address[ADDR_BITS-1 -: TAG_W];
        end
        if (s1_valid_reg)
        begin
            byp_set_reg <= s1_set_reg;
            byp_row_reg <= row_new;
            hit_reg     <= status.hit;
            way_reg     <= WAY_OUT_W'(way);
            set_reg     <= SET_OUT_W'(s1_set_reg);
            evicted_reg <= status.evicted;
            evtag_reg   <= status.evicted ? TAG_OUT_W'(old_tag) : '0;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign way_used    = way_reg;
    assign set_index   = set_reg;
    assign evicted     = evicted_reg;
    assign evicted_tag = evtag_reg;
    assign hit_total   = hit_cnt_reg;
    assign miss_total  = miss_cnt_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result beat missing two cycles after accept");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted))
        else $error("eviction reported on a hit");

    a_evtag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_tag == '0))
        else $error("evicted_tag nonzero without eviction");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (hit_total == $past(hit_total) + 1'b1
                           || $past(hit_total) == CNT_MAX))
        else $error("hit total did not advance on a hit");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (hit_total == $past(hit_total)
                            && (miss_total == $past(miss_total) + 1'b1
                                || $past(miss_total) == CNT_MAX)))
        else $error("totals wrong on a miss");

endmodule

[design/salc_row_ram.sv]
// ============================================================================
// salc_row_ram: set row memory
// One row per set holding the valid bits, tags and recency ages of all ways.
// One write port, one read port, registered read data.
// ============================================================================
module salc_row_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 320,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read returns the row as it was before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/salc_way_update.sv]
// ============================================================================
// salc_way_update: tag compare and true LRU update for one set
// Compares the tag against all ways side by side, picks the way to use
// (hit, lowest invalid, or oldest), and builds the updated row.
// ============================================================================
module salc_way_update
    import salc_pkg::*;
#(
    parameter int NUM_WAYS = NUM_WAYS_DEF,
    parameter int TAG_W    = 36
) (
    input  logic [NUM_WAYS-1:0]                                    valid_row,
    input  logic [NUM_WAYS-1:0][TAG_W-1:0]                         tag_row,
    input  logic [NUM_WAYS-1:0][((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] age_row,
    input  logic [TAG_W-1:0]                                       tag,
    output salc_status_t                                           status,
    output logic [((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0]     way,
    output logic [TAG_W-1:0]                                       old_tag,
    output logic [NUM_WAYS-1:0]                                    valid_new,
    output logic [NUM_WAYS-1:0][TAG_W-1:0]                         tag_new,
    output logic [NUM_WAYS-1:0][((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] age_new
);

    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W = WAY_W;
    localparam int LIM_W = AGE_W + 1;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);
    localparam logic [LIM_W-1:0] LIM_NONE = LIM_W'(NUM_WAYS);

    logic [NUM_WAYS-1:0] hit_vec;
    logic [NUM_WAYS-1:0] oldest;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    victim;
    logic                any_hit;
    logic                full;
    logic [LIM_W-1:0]    limit;

    // match and priority picks
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        victim  = '0;
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            hit_vec[k] = valid_row[k] && (tag_row[k] == tag);
            // oldest: greatest age, lowest index on a tie
            oldest[k] = 1'b1;
            for (int j = 0; j < NUM_WAYS; j++)
            begin
                if (j < k && age_row[j] >= age_row[k])
                begin
                    oldest[k] = 1'b0;
                end
                if (j > k && age_row[j] > age_row[k])
                begin
                    oldest[k] = 1'b0;
                end
            end
        end
        for (int k = NUM_WAYS - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                hit_way = WAY_W'(k);
            end
            if (!valid_row[k])
            begin
                inv_way = WAY_W'(k);
            end
            if (oldest[k])
            begin
                victim = WAY_W'(k);
            end
        end
        any_hit = |hit_vec;
        full    = &valid_row;
    end

    assign way = any_hit ? hit_way : (full ? victim : inv_way);

    // touch: ways younger than the touched one (all, on a fill) age by one
    always_comb
    begin
        limit = valid_row[way] ? {1'b0, age_row[way]} : LIM_NONE;
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            age_new[k] = age_row[k];
            if (WAY_W'(k) != way && valid_row[k]
                && {1'b0, age_row[k]} < limit && age_row[k] < AGE_MAX)
            begin
                age_new[k] = age_row[k] + 1'b1;
            end
        end
        age_new[way] = '0;

        valid_new      = valid_row;
        valid_new[way] = 1'b1;

        tag_new = tag_row;
        if (!any_hit)
        begin
            tag_new[way] = tag;
        end
    end

    assign old_tag        = tag_row[victim];
    assign status.hit     = any_hit;
    assign status.evicted = !any_hit && full;

endmodule
